### src/wts_pkg.sv
package wts_pkg;

  localparam int unsigned PosW = 7;
  localparam int unsigned CntW = 8;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] StopMark = 8'hAA;
  localparam logic [CntW-1:0] CntAllOnes = '1;
  localparam logic [CntW-1:0] NoStep = '1;

  typedef enum logic [2:0] {
    REG_BEGIN   = 3'd0,
    REG_END     = 3'd1,
    REG_LOOP    = 3'd2,
    REG_SPEED   = 3'd3,
    REG_ONESHOT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [7:0] mod_step;
    logic              restart;
    logic              clock_event;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] play_step;
    logic              restarted;
  } out_item_t;

  typedef struct packed {
    logic [PosW-1:0] begin_pos;
    logic [PosW-1:0] end_pos;
    logic [PosW-1:0] loop_pos;
    logic [CntW-1:0] speed;
    logic            oneshot;
  } cfg_t;

endpackage

### src/wavetable_step_sequencer.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (in_item_t)
// out       output     out_valid_o / out_ready_i out_data_o (out_item_t)
// cfg       input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// An accepted item is held in an input register, processed by the combinational
// core logic, and its result lands in the output register. One item per cycle is
// sustained while the output is not stalled. A stalled output holds its result
// while the input register still takes one more item. Reset clears the position,
// the divider, the pending requests, the configuration and both valid flags.
module wavetable_step_sequencer import wts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t result;
  cfg_t      cfg;
  logic      advance;

  assign advance     = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o  = ~in_vld_q | advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  wts_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  wts_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

endmodule

### src/wts_regs.sv
module wts_regs import wts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_BEGIN:   cfg_q.begin_pos <= pwdata[PosW-1:0];
        REG_END:     cfg_q.end_pos   <= pwdata[PosW-1:0];
        REG_LOOP:    cfg_q.loop_pos  <= pwdata[PosW-1:0];
        REG_SPEED:   cfg_q.speed     <= pwdata[CntW-1:0];
        REG_ONESHOT: cfg_q.oneshot   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BEGIN:   prdata = DataW'(cfg_q.begin_pos);
      REG_END:     prdata = DataW'(cfg_q.end_pos);
      REG_LOOP:    prdata = DataW'(cfg_q.loop_pos);
      REG_SPEED:   prdata = DataW'(cfg_q.speed);
      REG_ONESHOT: prdata = DataW'(cfg_q.oneshot);
      default:     prdata = '0;
    endcase
  end

endmodule

### src/wts_core.sv
module wts_core import wts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [CntW-1:0]  pos_q, pos_d;
  logic [CntW-1:0]  div_q, div_d;
  logic             rst_pend_q, rst_pend_d;
  logic             clk_pend_q, clk_pend_d;

  logic             rp, cp, fire, restarted;
  logic [PosW-1:0]  lo;
  logic [CntW-1:0]  span;
  logic [14:0]      prod;
  logic [CntW-1:0]  play;

  // Modulated position: lo + mod_step * span / 128, span always 1..128.
  always_comb begin
    if (cfg_i.end_pos > cfg_i.begin_pos) begin
      lo   = cfg_i.begin_pos;
      span = CntW'(cfg_i.end_pos) - CntW'(cfg_i.begin_pos) + 8'd1;
    end else begin
      lo   = cfg_i.end_pos;
      span = CntW'(cfg_i.begin_pos) - CntW'(cfg_i.end_pos) + 8'd1;
    end
    prod = 15'(item_i.mod_step[6:0]) * 15'(span);
  end

  always_comb begin
    rp         = rst_pend_q | item_i.restart;
    cp         = clk_pend_q | item_i.clock_event;
    pos_d      = pos_q;
    div_d      = div_q;
    rst_pend_d = rp;
    clk_pend_d = cp;
    fire       = 1'b0;
    restarted  = 1'b0;
    play       = NoStep;
    if (!item_i.mod_step[7]) begin
      play = CntW'(lo) + prod[14:7];
    end else begin
      rst_pend_d = 1'b0;
      clk_pend_d = 1'b0;
      if (rp) begin
        restarted = 1'b1;
        div_d     = CntAllOnes;
        pos_d     = CntW'(cfg_i.begin_pos) - 8'd1;
      end
      if (cp) begin
        div_d = div_d + 8'd1;
        if (div_d == '0 || div_d > cfg_i.speed) begin
          div_d = '0;
          fire  = 1'b1;
        end
      end
      if (fire && pos_d != StopMark) begin
        pos_d = pos_d + 8'd1;
        if (pos_d > CntW'(cfg_i.end_pos)) begin
          restarted = 1'b1;
          pos_d     = cfg_i.oneshot ? StopMark : CntW'(cfg_i.loop_pos);
        end
        play = pos_d;
      end
    end
    result_o.play_step = signed'(play);
    result_o.restarted = restarted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      div_q      <= '0;
      rst_pend_q <= 1'b0;
      clk_pend_q <= 1'b0;
    end else if (step_en_i) begin
      pos_q      <= pos_d;
      div_q      <= div_d;
      rst_pend_q <= rst_pend_d;
      clk_pend_q <= clk_pend_d;
    end
  end

endmodule
